>>> rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by the channel interfaces, the storage cell and the top level; no dependencies.

package spq_pkg;

   // Queue geometry.
   localparam int DEPTH       = 16;
   localparam int VALUE_BITS  = 16;
   localparam int INDEX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);

   // Fixed widths of the transaction fields.
   localparam int KIND_BITS   = 2;
   localparam int FIELD_BITS  = 16;
   localparam int STATUS_BITS = 2;
   localparam int CNT_FIELD_BITS = 5;

   // Operation codes carried in the kind field.
   typedef enum logic [KIND_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PEEK   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every storage cell in a cycle.
   typedef struct packed {
      logic                  insert;
      logic                  shift_down;
      logic [VALUE_BITS-1:0] value;
   } cell_cmd_type;

endpackage

>>> rtl/spq_channels.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on spq_pkg for the field widths.

interface spq_req_if;
   logic                           valid;
   logic                           ready;
   logic [spq_pkg::KIND_BITS-1:0]  kind;
   logic [spq_pkg::FIELD_BITS-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface spq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [spq_pkg::FIELD_BITS-1:0]     top_value;
   logic [spq_pkg::STATUS_BITS-1:0]    status;
   logic [spq_pkg::CNT_FIELD_BITS-1:0] count;
   logic                               is_empty;
   logic                               is_full;

   modport source (output valid, output top_value, output status, output count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input top_value, input status, input count,
                   input is_empty, input is_full, output ready);
endinterface

>>> rtl/spq_cell.sv
// One storage slot of the sorted row; exchanges values with its two neighbors.
// Depends on spq_pkg for widths and the command struct.

module spq_cell (
   input  logic                               clock,
   input  spq_pkg::cell_cmd_type              cmd,
   input  logic [spq_pkg::INDEX_BITS-1:0]     slot_idx,
   input  logic [spq_pkg::COUNT_BITS-1:0]     count,
   input  logic [spq_pkg::VALUE_BITS-1:0]     prev_value,
   input  logic                               prev_le,
   input  logic [spq_pkg::VALUE_BITS-1:0]     next_value,
   output logic [spq_pkg::VALUE_BITS-1:0]     value_out,
   output logic                               le_out,
   output logic [spq_pkg::VALUE_BITS-1:0]     last_value
);

   logic [spq_pkg::VALUE_BITS-1:0] value_ff;
   logic [spq_pkg::VALUE_BITS-1:0] value_in;
   logic                           occupied;
   logic                           is_last;

   // The slot holds a value when it lies below the fill count.
   assign occupied = spq_pkg::COUNT_BITS'(slot_idx) < count;
   assign is_last  = occupied &&
                     ((spq_pkg::COUNT_BITS'(slot_idx) + 1'b1) == count);

   // An occupied slot stays put on insert when its value is not above the new one.
   assign le_out     = occupied && (value_ff <= cmd.value);
   assign value_out  = value_ff;
   assign last_value = is_last ? value_ff : '0;

   // Insert keeps, takes the new value, or takes the lower neighbor's value;
   // removing the smallest shifts every slot down by one.
   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (!le_out) begin
            value_in = prev_le ? cmd.value : prev_value;
         end
      end else if (cmd.shift_down) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

>>> rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: control, fill count and response register.
// Depends on spq_pkg, the channel interfaces and spq_cell.

// A bounded priority queue of DEPTH values held in ascending order in a row of
// cells. Each request transaction (insert, remove top, peek top, clear) is
// finished in the cycle it is accepted and its response appears in the next
// cycle; a new request is accepted every cycle as long as the response side
// keeps taking responses, so the sustained rate is one transaction per clock.
// That figure is set by the cell row, where every cell decides its next value
// in parallel from its own value and its neighbors'. The csr_wr_data bit selects
// smallest value on top (1) or largest on top (0) and may be changed while
// values are held. Reset empties the queue at once; no clearing pass is needed.

module sorted_priority_queue (
   input  logic          clock,
   input  logic          reset,
   spq_req_if.sink       req_chan,
   spq_rsp_if.source     rsp_chan,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data
);

   localparam int VB = spq_pkg::VALUE_BITS;
   localparam int CB = spq_pkg::COUNT_BITS;

   logic                           mode_ff;
   logic [CB-1:0]                  count_ff;
   logic [CB-1:0]                  count_in;
   logic                           rsp_valid_ff;
   logic [spq_pkg::FIELD_BITS-1:0] rsp_top_ff;
   logic [spq_pkg::FIELD_BITS-1:0] rsp_top_in;
   spq_pkg::status_type            rsp_status_ff;
   spq_pkg::status_type            rsp_status_in;
   logic [CB-1:0]                  rsp_count_ff;
   logic                           rsp_empty_ff;
   logic                           rsp_full_ff;

   logic                           accept;
   logic                           q_empty;
   logic                           q_full;
   spq_pkg::op_type                op;
   spq_pkg::cell_cmd_type          cmd;
   logic [VB-1:0]                  top_val;
   logic [VB-1:0]                  largest_val;

   logic [VB-1:0] cell_value [spq_pkg::DEPTH];
   logic [VB-1:0] cell_last  [spq_pkg::DEPTH];
   logic          cell_le    [spq_pkg::DEPTH];

   assign accept  = req_chan.valid && req_chan.ready;
   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CB'(spq_pkg::DEPTH));
   assign op      = spq_pkg::op_type'(req_chan.kind);

   // A response register separates the two sides; a waiting response that is
   // being taken in this cycle does not block the next request.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   // Command broadcast to the cell row.
   always_comb begin
      cmd.value      = VB'(req_chan.value);
      cmd.insert     = accept && (op == spq_pkg::OP_INSERT) && !q_full;
      cmd.shift_down = accept && (op == spq_pkg::OP_REMOVE) && !q_empty && mode_ff;
   end

   // Row of storage cells, slot 0 holding the smallest value.
   for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
      logic [VB-1:0] prev_v;
      logic          prev_l;
      logic [VB-1:0] next_v;

      if (i == 0) begin : g_first
         assign prev_v = cmd.value;
         assign prev_l = 1'b1;
      end else begin : g_mid
         assign prev_v = cell_value[i-1];
         assign prev_l = cell_le[i-1];
      end

      if (i == spq_pkg::DEPTH - 1) begin : g_end
         assign next_v = cell_value[i];
      end else begin : g_inner
         assign next_v = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .slot_idx   (spq_pkg::INDEX_BITS'(i)),
         .count      (count_ff),
         .prev_value (prev_v),
         .prev_le    (prev_l),
         .next_value (next_v),
         .value_out  (cell_value[i]),
         .le_out     (cell_le[i]),
         .last_value (cell_last[i])
      );
   end

   // The largest value sits in the last occupied slot; only that cell drives
   // a nonzero word, so the words are ORed together.
   always_comb begin
      largest_val = '0;
      for (int i = 0; i < spq_pkg::DEPTH; i++) begin
         largest_val = largest_val | cell_last[i];
      end
      top_val = mode_ff ? cell_value[0] : largest_val;
   end

   // Operation decode: next fill count and response fields.
   always_comb begin
      count_in      = count_ff;
      rsp_top_in    = '0;
      rsp_status_in = spq_pkg::ST_OK;
      unique case (op)
         spq_pkg::OP_INSERT: begin
            if (q_full) begin
               rsp_status_in = spq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         spq_pkg::OP_REMOVE: begin
            if (q_empty) begin
               rsp_status_in = spq_pkg::ST_EMPTY;
            end else begin
               rsp_top_in = spq_pkg::FIELD_BITS'(top_val);
               count_in   = count_ff - 1'b1;
            end
         end
         spq_pkg::OP_PEEK: begin
            if (q_empty) begin
               rsp_status_in = spq_pkg::ST_EMPTY;
            end else begin
               rsp_top_in = spq_pkg::FIELD_BITS'(top_val);
            end
         end
         spq_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Control state: mode register, fill count and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload, loaded with each accepted transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_top_ff    <= rsp_top_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (count_in == CB'(spq_pkg::DEPTH));
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.top_value = rsp_top_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.count     = spq_pkg::CNT_FIELD_BITS'(rsp_count_ff);
   assign rsp_chan.is_empty  = rsp_empty_ff;
   assign rsp_chan.is_full   = rsp_full_ff;

   // The fill count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(spq_pkg::DEPTH))
      else $error("fill count above capacity");

   // A successful insert grows the count by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the count");

   // The two lowest slots stay in ascending order while both are occupied.
   a_row_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CB'(2) |-> cell_value[0] <= cell_value[1])
      else $error("cell row out of order");

   // Every accepted transaction yields a pending response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("missing response after accepted transaction");

   // The reported empty flag agrees with the reported count.
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_empty_ff == (rsp_count_ff == '0))
      else $error("empty flag disagrees with count");

endmodule
